/* hw/rtl/bf2h_pkg.sv */
package bf2h_pkg;

	typedef logic [15:0] bf16_t;
	typedef logic [15:0] fp16_t;

	localparam logic [7:0] EXP8_MAX = 8'hFF;
	// bfloat16 exponent codes that bound the half-precision ranges
	localparam logic [7:0] EXP8_OVF     = 8'd143;  // rebiased exponent 31
	localparam logic [7:0] EXP8_REBIAS  = 8'd112;  // 127 - 15, rebiased exponent 0
	localparam logic [7:0] EXP8_SUB_MIN = 8'd102;  // rebiased exponent -10
	localparam logic [7:0] EXP8_SHIFT   = 8'd126;  // shift = 126 - exp8 in the subnormal band

	localparam logic [14:0] FP16_INF  = 15'h7C00;
	localparam logic [14:0] FP16_QNAN = 15'h7E00;

endpackage

/* hw/rtl/bf16_if.sv */
interface bf16_if
	import bf2h_pkg::*;
;
	logic  valid;
	logic  ready;
	bf16_t bf16_in;

	modport source (output valid, output bf16_in, input ready);
	modport sink (input valid, input bf16_in, output ready);
endinterface

/* hw/rtl/fp16_if.sv */
interface fp16_if
	import bf2h_pkg::*;
;
	logic  valid;
	logic  ready;
	fp16_t fp16_out;

	modport source (output valid, output fp16_out, input ready);
	modport sink (input valid, input fp16_out, output ready);
endinterface

/* hw/rtl/bf2h_core.sv */
module bf2h_core
	import bf2h_pkg::*;
(
	input  bf16_t bf16_in,
	output fp16_t fp16_out
);

	logic        sign;
	logic [7:0]  exp8;
	logic [6:0]  frac7;
	logic [23:0] sig;
	logic [4:0]  sh;
	logic [23:0] rnd_word;
	logic [9:0]  sub_mant;
	logic [10:0] sub_val;
	logic [14:0] mag;

	assign sign  = bf16_in[15];
	assign exp8  = bf16_in[14:7];
	assign frac7 = bf16_in[6:0];

	always_comb begin
		// significand with hidden bit, aligned as a binary32 fraction
		sig      = {1'b1, frac7, 16'h0000};
		sh       = 5'(EXP8_SHIFT - exp8);
		sub_mant = 10'(sig >> sh);
		// first dropped bit decides half-up rounding
		rnd_word = sig >> (sh - 5'd1);
		sub_val  = {1'b0, sub_mant} + {10'd0, rnd_word[0]};

		if (exp8 == EXP8_MAX) begin
			mag = (frac7 != 7'd0) ? FP16_QNAN : FP16_INF;
		end else if (exp8 >= EXP8_OVF) begin
			mag = FP16_INF;
		end else if (exp8 > EXP8_REBIAS) begin
			// exact: the dropped fraction bits are all zero
			mag = {5'(exp8 - EXP8_REBIAS), frac7, 3'b000};
		end else if (exp8 >= EXP8_SUB_MIN) begin
			// a carry out of the mantissa lands in the exponent field
			mag = {4'd0, sub_val};
		end else begin
			mag = 15'd0;
		end

		fp16_out = {sign, mag};
	end

endmodule

/* hw/rtl/bf16_to_fp16_convert.sv */
// Converts a stream of bfloat16 words to IEEE binary16, one word per transaction.
// Zeros keep their sign, infinities stay infinite, every NaN becomes the quiet
// NaN 0x7E00 with its sign, magnitudes beyond the half range saturate to signed
// infinity, values in the subnormal range are rounded half-up on the first
// dropped bit, and anything smaller flushes to signed zero. The block accepts a
// word every cycle while the output is not stalled, and each result passes
// through one input register and one result register that surround a single
// pass of shift and compare logic. With the output stalled, the input register
// still takes one more word before ready drops.
module bf16_to_fp16_convert
	import bf2h_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	bf16_if.sink         bf16,
	fp16_if.source       fp16
);

	logic  valid_s1;
	bf16_t word_s1;
	logic  valid_s2;
	fp16_t half_s2;
	fp16_t half_comb;
	logic  adv_s1;
	logic  adv_s2;

	// advance a stage when it is empty or its content moves on
	assign adv_s2 = !valid_s2 || fp16.ready;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign bf16.ready    = adv_s1;
	assign fp16.valid    = valid_s2;
	assign fp16.fp16_out = half_s2;

	bf2h_core u_core (
		.bf16_in  (word_s1),
		.fp16_out (half_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= bf16.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && bf16.valid) begin
			word_s1 <= bf16.bf16_in;
		end
		if (adv_s2 && valid_s1) begin
			half_s2 <= half_comb;
		end
	end

endmodule
